// ===== rtl/multi_stage_onoff_controller_assert.svh =====
// Assertion macros for the multi-stage on/off controller.
`ifndef MULTI_STAGE_ONOFF_CONTROLLER_ASSERT_SVH
`define MULTI_STAGE_ONOFF_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define MSOC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("msoc assertion failed");
`define MSOC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("msoc forbidden condition seen");
`else
`define MSOC_ASSERT(lbl, clk, rst_n, prop)
`define MSOC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/msoc_pkg.sv =====
// Types and constants shared by the multi-stage on/off controller.
package msoc_pkg;

  localparam int unsigned VAL_W  = 20;  // holds negated Q12.4 plus two margins
  localparam int unsigned HYST_W = 15;
  localparam int unsigned STG_W  = 3;
  localparam int unsigned LINE_W = 4;
  localparam int unsigned NREGS  = 4;   // on-hysteresis registers
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 16;

  localparam logic [CIDX_W-1:0] CFG_OFF_HYST  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_INVERT    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DEAD_TIME = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_STAGE1    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_STAGE2    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_STAGE3    = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_STAGE4    = 3'd6;

  typedef struct packed {
    logic signed [15:0] process_value;
    logic signed [15:0] setpoint;
    logic [31:0]        time_ms;
  } msoc_in_t;

  typedef struct packed {
    logic [2:0] active_stage;
    logic [3:0] stage_lines;
    logic       waiting_dead_time;
  } msoc_out_t;

  typedef struct packed {
    logic [HYST_W-1:0] off_hyst;
    logic              invert;
    logic [15:0]       dead_time;
  } msoc_cfg_t;

endpackage

// ===== rtl/msoc_cmp.sv =====
// Shared add-and-compare unit: value against base - sub + add.
module msoc_cmp (
  input  logic signed [msoc_pkg::VAL_W-1:0]  val_i,
  input  logic signed [msoc_pkg::VAL_W-1:0]  base_i,
  input  logic        [msoc_pkg::HYST_W-1:0] sub_i,
  input  logic        [msoc_pkg::HYST_W-1:0] add_i,
  output logic                               gt_o,
  output logic                               lt_o
);
  import msoc_pkg::*;

  logic signed [VAL_W-1:0] rhs;

  assign rhs  = base_i - signed'(VAL_W'(sub_i)) + signed'(VAL_W'(add_i));
  assign gt_o = val_i > rhs;
  assign lt_o = val_i < rhs;

endmodule

// ===== rtl/msoc_cfg.sv =====
// Configuration registers with a stage hysteresis read port.
module msoc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic        [msoc_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic        [msoc_pkg::CDAT_W-1:0] cfg_wdata_i,
  input  logic        [msoc_pkg::STG_W-1:0]  rd_idx_i,
  output msoc_pkg::msoc_cfg_t                cfg_o,
  output logic        [msoc_pkg::HYST_W-1:0] rd_hyst_o
);
  import msoc_pkg::*;

  msoc_cfg_t         cfg_q;
  logic [HYST_W-1:0] hyst_q [NREGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_hyst  <= HYST_W'(16);
      cfg_q.invert    <= 1'b0;
      cfg_q.dead_time <= 16'd200;
      hyst_q[0]       <= HYST_W'(16);
      hyst_q[1]       <= HYST_W'(32);
      hyst_q[2]       <= HYST_W'(48);
      hyst_q[3]       <= HYST_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFF_HYST:  cfg_q.off_hyst  <= cfg_wdata_i[HYST_W-1:0];
        CFG_INVERT:    cfg_q.invert    <= cfg_wdata_i[0];
        CFG_DEAD_TIME: cfg_q.dead_time <= cfg_wdata_i;
        CFG_STAGE1:    hyst_q[0]       <= cfg_wdata_i[HYST_W-1:0];
        CFG_STAGE2:    hyst_q[1]       <= cfg_wdata_i[HYST_W-1:0];
        CFG_STAGE3:    hyst_q[2]       <= cfg_wdata_i[HYST_W-1:0];
        CFG_STAGE4:    hyst_q[3]       <= cfg_wdata_i[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
  // stages without a register read as disabled
  assign rd_hyst_o = (rd_idx_i < STG_W'(NREGS)) ? hyst_q[rd_idx_i[1:0]] : '0;

endmodule

// ===== rtl/multi_stage_onoff_controller.sv =====
// Multi-stage on/off controller: a word is accepted when in_stall_o is low and the
// block is idle; it runs the off check and, if not above the off margin, a scan of
// each stage through the shared add/compare unit and the latch check, then the
// dead-time update, before the next word is accepted. The result lands in an output
// register, so the block goes idle while the result waits to be taken. Configuration
// is a plain indexed write port; writes beyond the register list are ignored.
`include "multi_stage_onoff_controller_assert.svh"
module multi_stage_onoff_controller #(
  parameter int unsigned STAGES = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic        [msoc_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic        [msoc_pkg::CDAT_W-1:0] cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  msoc_pkg::msoc_in_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output msoc_pkg::msoc_out_t                out_word_o
);
  import msoc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_LATCH = 3'd3;
  localparam logic [2:0] S_DEAD  = 3'd4;

  localparam logic [STG_W-1:0] LastIdx  = STG_W'(STAGES - 1);
  localparam logic [STG_W-1:0] NumStage = STG_W'(STAGES);

  msoc_cfg_t         cfg;
  logic [STG_W-1:0]  rd_idx;
  logic [HYST_W-1:0] rd_hyst;
  logic [HYST_W-1:0] cmp_sub, cmp_add;
  logic              cmp_gt, cmp_lt;

  logic [2:0]              state_q, state_d;
  logic [STG_W-1:0]        idx_q, idx_d;
  logic [STG_W-1:0]        best_q, best_d;
  logic [HYST_W-1:0]       best_h_q, best_h_d;
  logic [STG_W-1:0]        latched_q, latched_d;
  logic [STG_W-1:0]        des_q, des_d;
  logic [STG_W-1:0]        drv_q, drv_d;
  logic [STG_W-1:0]        pend_q, pend_d;
  logic                    dead_q, dead_d;
  logic [31:0]             start_q, start_d;
  logic signed [VAL_W-1:0] pv_q, pv_d, sp_q, sp_d;
  logic [31:0]             now_q, now_d;
  logic                    out_valid_q, out_valid_d;
  msoc_out_t               out_q, out_d;
  logic signed [VAL_W-1:0] pv_ext, sp_ext;

  msoc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_idx_i    (rd_idx),
    .cfg_o       (cfg),
    .rd_hyst_o   (rd_hyst)
  );

  msoc_cmp u_cmp (
    .val_i  (pv_q),
    .base_i (sp_q),
    .sub_i  (cmp_sub),
    .add_i  (cmp_add),
    .gt_o   (cmp_gt),
    .lt_o   (cmp_lt)
  );

  assign pv_ext = VAL_W'(in_word_i.process_value);
  assign sp_ext = VAL_W'(in_word_i.setpoint);

  always_comb begin
    logic [STG_W-1:0] pick;
    logic             ndt;
    logic [STG_W-1:0] npend, ndrv;
    logic [31:0]      nstart;
    pick        = '0;
    ndt         = dead_q;
    npend       = pend_q;
    ndrv        = drv_q;
    nstart      = start_q;
    state_d     = state_q;
    idx_d       = idx_q;
    best_d      = best_q;
    best_h_d    = best_h_q;
    latched_d   = latched_q;
    des_d       = des_q;
    drv_d       = drv_q;
    pend_d      = pend_q;
    dead_d      = dead_q;
    start_d     = start_q;
    pv_d        = pv_q;
    sp_d        = sp_q;
    now_d       = now_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    rd_idx      = idx_q;
    cmp_sub     = '0;
    cmp_add     = cfg.off_hyst;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pv_d    = cfg.invert ? -pv_ext : pv_ext;
          sp_d    = cfg.invert ? -sp_ext : sp_ext;
          now_d   = in_word_i.time_ms;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        // above setpoint + off margin: everything off
        if (cmp_gt) begin
          latched_d = '0;
          des_d     = '0;
          state_d   = S_DEAD;
        end else begin
          idx_d    = '0;
          best_d   = '0;
          best_h_d = '0;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_sub = rd_hyst;
        cmp_add = '0;
        if (rd_hyst != '0 && cmp_lt && (best_q == '0 || rd_hyst > best_h_q)) begin
          best_d   = idx_q + STG_W'(1);
          best_h_d = rd_hyst;
        end
        if (idx_q == LastIdx) state_d = S_LATCH;
        else idx_d = idx_q + STG_W'(1);
      end
      S_LATCH: begin
        rd_idx  = latched_q - STG_W'(1);
        cmp_sub = rd_hyst;
        if (latched_q == '0) pick = best_q;
        else if (latched_q > NumStage || rd_hyst == '0) pick = best_q;
        else if (cmp_gt) pick = best_q;      // past its release level
        else if (best_q != '0 && best_h_q > rd_hyst) pick = best_q;
        else pick = latched_q;
        latched_d = pick;
        des_d     = pick;
        state_d   = S_DEAD;
      end
      S_DEAD: begin
        if (!out_valid_q || !out_stall_i) begin
          if (dead_q) begin
            if (des_q == '0) begin
              ndt   = 1'b0;
              npend = '0;
              ndrv  = '0;
            end else if (des_q != pend_q) begin
              npend  = des_q;
              nstart = now_q;
            end else if ((now_q - start_q) >= 32'(cfg.dead_time)) begin
              ndt = 1'b0;
              if (pend_q != '0) ndrv = pend_q;
              npend = '0;
            end
          end
          if (!ndt && des_q != ndrv) begin
            // break before make between two stages
            if (ndrv != '0 && des_q != '0) begin
              if (cfg.dead_time == '0) begin
                ndrv = des_q;
              end else begin
                ndrv   = '0;
                npend  = des_q;
                nstart = now_q;
                ndt    = 1'b1;
              end
            end else begin
              ndrv = des_q;
            end
          end
          drv_d   = ndrv;
          pend_d  = npend;
          dead_d  = ndt;
          start_d = nstart;
          out_d.active_stage      = ndrv;
          out_d.stage_lines       = (ndrv != '0 && ndrv <= STG_W'(LINE_W))
                                    ? (LINE_W'(1) << (ndrv - STG_W'(1))) : '0;
          out_d.waiting_dead_time = ndt;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      best_q      <= '0;
      best_h_q    <= '0;
      latched_q   <= '0;
      des_q       <= '0;
      drv_q       <= '0;
      pend_q      <= '0;
      dead_q      <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      best_q      <= best_d;
      best_h_q    <= best_h_d;
      latched_q   <= latched_d;
      des_q       <= des_d;
      drv_q       <= drv_d;
      pend_q      <= pend_d;
      dead_q      <= dead_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q  <= pv_d;
    sp_q  <= sp_d;
    now_q <= now_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `MSOC_ASSERT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o |=> state_q == S_PREP)
  `MSOC_ASSERT(a_dead_has_target, clk_i, rst_ni, dead_q |-> pend_q != '0)
  `MSOC_ASSERT(a_lines_onehot, clk_i, rst_ni, out_valid_o && out_word_o.active_stage != '0 && out_word_o.active_stage <= 3'd4 |-> $onehot(out_word_o.stage_lines))
  `MSOC_ASSERT_NEVER(a_drv_range, clk_i, rst_ni, drv_q > NumStage || latched_q > NumStage)

endmodule

// ===== sim/tb_multi_stage_onoff_controller.sv =====
// Self-checking testbench for the multi-stage on/off controller: directed and random ticks.
module tb_multi_stage_onoff_controller;
  import msoc_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;  // no register behind this index
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_PER_PHASE = 105;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i = '0;
  logic [CDAT_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  msoc_in_t          in_word_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  msoc_out_t         out_word_o;

  multi_stage_onoff_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // register copies, reset values
  logic [14:0] cfg_off_hyst = 15'd16;
  logic        cfg_invert = 1'b0;
  logic [15:0] cfg_dead_ms = 16'd200;
  logic [14:0] cfg_on_hyst [4] = '{15'd16, 15'd32, 15'd48, 15'd64};

  // controller state copies
  logic [2:0]  latch_stg = '0;
  logic [2:0]  drive_stg = '0;
  logic        dead_active = 1'b0;
  logic [2:0]  pend_stg = '0;
  logic [31:0] dead_start = '0;

  msoc_in_t  tick_queue [$];
  msoc_out_t want_outputs [$];
  msoc_out_t want_now;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_len = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;
  int err_cnt = 0;
  int ticks_taken = 0;
  int results_seen = 0;
  int waits_seen = 0;
  int changes_seen = 0;
  int settings_cnt = 1;
  logic [31:0] ms_now = 32'd5000;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic msoc_out_t thermostat_step(msoc_in_t w);
    int pv, sp, off, h, best_h, lh;
    logic [2:0] best, target, prev;
    msoc_out_t r;
    pv = $signed(w.process_value);
    sp = $signed(w.setpoint);
    off = cfg_off_hyst;
    prev = drive_stg;
    if (cfg_invert) begin
      pv = -pv;
      sp = -sp;
    end
    target = '0;
    if (pv > sp + off) begin
      latch_stg = '0;
    end else begin
      best = '0;
      best_h = 0;
      for (int i = 0; i < 4; i++) begin
        h = cfg_on_hyst[i];
        if (h > 0 && pv < sp - h && (best == 0 || h > best_h)) begin
          best = 3'(i + 1);
          best_h = h;
        end
      end
      if (latch_stg != 0) begin
        lh = (latch_stg <= 4) ? int'(cfg_on_hyst[latch_stg - 1]) : 0;
        // stale latch, release level passed, or a bigger stage qualifies
        if (lh <= 0 || pv > sp - lh + off || (best != 0 && best_h > lh))
          latch_stg = best;
        target = latch_stg;
      end else begin
        target = best;
        latch_stg = best;
      end
    end

    if (dead_active) begin
      if (target == 0) begin
        dead_active = 1'b0;
        pend_stg = '0;
        drive_stg = '0;
      end else if (target != pend_stg) begin
        pend_stg = target;
        dead_start = w.time_ms;
      end else if (w.time_ms - dead_start >= cfg_dead_ms) begin
        dead_active = 1'b0;
        if (pend_stg != 0) drive_stg = pend_stg;
        pend_stg = '0;
      end
    end

    // break before make on a stage-to-stage switch
    if (!dead_active && target != drive_stg) begin
      if (drive_stg != 0 && target != 0) begin
        drive_stg = '0;
        if (cfg_dead_ms == 0) begin
          drive_stg = target;
        end else begin
          pend_stg = target;
          dead_start = w.time_ms;
          dead_active = 1'b1;
        end
      end else begin
        drive_stg = target;
      end
    end

    r.active_stage = drive_stg;
    r.stage_lines = 4'b0;
    if (drive_stg >= 1 && drive_stg <= 4) r.stage_lines[drive_stg - 1] = 1'b1;
    r.waiting_dead_time = dead_active;
    if (dead_active) waits_seen++;
    if (prev != drive_stg) changes_seen++;
    return r;
  endfunction

  task automatic flag_error(string msg);
    if (err_cnt < 100) $display("ERROR t=%0t %s", $time, msg);
    err_cnt++;
  endtask

  task automatic add_tick(int pv, int sp, logic [31:0] t);
    msoc_in_t w;
    if (pv > 32767) pv = 32767;
    if (pv < -32768) pv = -32768;
    if (sp > 32767) sp = 32767;
    if (sp < -32768) sp = -32768;
    w.process_value = pv[15:0];
    w.setpoint = sp[15:0];
    w.time_ms = t;
    tick_queue.insert(tick_queue.size(), w);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_OFF_HYST:  cfg_off_hyst = data[14:0];
      CFG_INVERT:    cfg_invert = data[0];
      CFG_DEAD_TIME: cfg_dead_ms = data;
      CFG_STAGE1:    cfg_on_hyst[0] = data[14:0];
      CFG_STAGE2:    cfg_on_hyst[1] = data[14:0];
      CFG_STAGE3:    cfg_on_hyst[2] = data[14:0];
      CFG_STAGE4:    cfg_on_hyst[3] = data[14:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [15:0] off, logic [15:0] inv, logic [15:0] dead,
                          logic [15:0] h1, logic [15:0] h2, logic [15:0] h3,
                          logic [15:0] h4);
    write_reg(CFG_OFF_HYST, off);
    write_reg(CFG_INVERT, inv);
    write_reg(CFG_DEAD_TIME, dead);
    write_reg(CFG_STAGE1, h1);
    write_reg(CFG_STAGE2, h2);
    write_reg(CFG_STAGE3, h3);
    write_reg(CFG_STAGE4, h4);
    write_reg(CFG_UNUSED, 16'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_cnt++;
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid_i || want_outputs.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // sender: predicts on every accepted word, then offers the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want_outputs.insert(want_outputs.size(), thermostat_step(in_word_i));
        ticks_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_word_i <= tick_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: compares each taken word, drives stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (want_outputs.size() == 0) begin
          flag_error("result word with no tick outstanding");
        end else begin
          want_now = want_outputs.pop_front();
          if (out_word_o.active_stage !== want_now.active_stage)
            flag_error($sformatf("active_stage got %0d want %0d",
                                 out_word_o.active_stage, want_now.active_stage));
          if (out_word_o.stage_lines !== want_now.stage_lines)
            flag_error($sformatf("stage_lines got %b want %b",
                                 out_word_o.stage_lines, want_now.stage_lines));
          if (out_word_o.waiting_dead_time !== want_now.waiting_dead_time)
            flag_error($sformatf("waiting_dead_time got %b want %b",
                                 out_word_o.waiting_dead_time,
                                 want_now.waiting_dead_time));
        end
      end
      if (rx_hold_len != 0) begin
        rx_hold_left = rx_hold_len;
        rx_hold_len = 0;
      end
      if (rx_hold_left != 0) rx_hold_left--;
      out_stall_i <= (rx_hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int base_sp, lvl, h, mark, t;
    base_sp = 0;
    lvl = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extremes, dead time, timer restart, wrap, zero target
    @(negedge clk_i);
    tx_idle_pct = 20;
    rx_stall_pct = 68;
    add_tick(32767, -32768, 32'd0);
    add_tick(-32768, 32767, 32'd10);
    add_tick(-40, 0, 32'd1000);
    add_tick(-40, 0, 32'd1100);
    add_tick(-60, 0, 32'd1150);
    add_tick(-60, 0, 32'd1349);
    add_tick(-60, 0, 32'd1350);
    add_tick(20, 0, 32'd1400);
    add_tick(-20, 0, 32'hFFFF_FF00);
    add_tick(-70, 0, 32'hFFFF_FFF0);
    add_tick(-70, 0, 32'h0000_0050);
    add_tick(-70, 0, 32'h0000_00C0);
    add_tick(-20, 0, 32'h0000_0200);
    add_tick(100, 0, 32'h0000_0210);
    add_tick(-100, 0, 32'h0000_0300);
    wait_drained();

    // stage 4 latched, then disabled; tie between stages 2 and 3; cooling
    set_regs(16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd48, 16'd48, 16'd0);
    @(negedge clk_i);
    add_tick(100, 0, 32'd0);
    add_tick(-32768, 32767, 32'd1);
    add_tick(32767, -32768, 32'd2);
    add_tick(1, 0, 32'd3);
    add_tick(32767, 32767, 32'hFFFF_FFFF);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_regs(16'd16, 16'd0, 16'd200, 16'd16, 16'd32, 16'd48, 16'd64);
        1: begin
          ms_now = 32'hFFFF_F000;
          set_regs(16'($urandom_range(64)), 16'd1, 16'($urandom_range(1, 300)),
                   16'($urandom_range(3) == 0 ? 0 : $urandom_range(1, 96)),
                   16'($urandom_range(3) == 0 ? 0 : $urandom_range(1, 96)),
                   16'($urandom_range(3) == 0 ? 0 : $urandom_range(1, 96)),
                   16'($urandom_range(3) == 0 ? 0 : $urandom_range(1, 96)));
        end
        2: set_regs(16'd0, 16'd0, 16'hFFFF, 16'h7FFF, 16'd1, 16'h7FFF, 16'd16);
        3: begin
          t = $urandom_range(1, 200);
          set_regs(16'($urandom_range(64)), 16'($urandom_range(1)), 16'd0, 16'(t),
                   16'($urandom_range(200)), 16'(t),
                   16'($urandom_range(3) == 0 ? 0 : $urandom_range(1, 200)));
        end
        4: set_regs(16'h7FFF, 16'd0, 16'd50, 16'd100, 16'd200, 16'd300, 16'd400);
        default: set_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)));
      endcase
      @(negedge clk_i);
      tx_idle_pct = (p < 2) ? 20 : (p < 4) ? 68 : 0;
      rx_stall_pct = (p < 2) ? 68 : (p < 4) ? 20 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if ($urandom_range(99) < 12) begin
          tick_queue.insert(tick_queue.size(), msoc_in_t'({$urandom, $urandom}));
        end else begin
          if ($urandom_range(99) < 10) base_sp = int'($urandom_range(4000)) - 2000;
          // hold a level for a few ticks so dead times can run out
          if ($urandom_range(99) < 35) begin
            h = cfg_on_hyst[$urandom_range(3)];
            case ($urandom_range(4))
              0: lvl = -h - int'($urandom_range(1, 8));
              1: lvl = -h + int'($urandom_range(1));
              2: lvl = -h + int'(cfg_off_hyst) + int'($urandom_range(8)) - 4;
              3: lvl = int'(cfg_off_hyst) + int'($urandom_range(8)) - 3;
              default: lvl = int'($urandom_range(400)) - 300;
            endcase
          end
          ms_now += ($urandom_range(9) == 0) ? 32'(cfg_dead_ms)
                                             : $urandom_range(cfg_dead_ms / 2 + 20);
          add_tick(cfg_invert ? base_sp - lvl : base_sp + lvl, base_sp, ms_now);
        end
      end
      if (p == 4) begin
        // long receiver hold-off with the sender still pushing
        mark = ticks_taken;
        while (ticks_taken < mark + 10) @(posedge clk_i);
        @(negedge clk_i);
        rx_hold_len = 150;
      end
      wait_drained();
    end

    if (want_outputs.size() != 0)
      flag_error($sformatf("%0d results never arrived", want_outputs.size()));
    $display("Covered %0d ticks, %0d results, over %0d register settings",
             ticks_taken, results_seen, settings_cnt);
    $display("Saw %0d stage changes and %0d results waiting out a dead time",
             changes_seen, waits_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
